// ===== hw/rtl/ppc_pkg.sv =====
// Shared types, register indexes and constants of the primitive pixel coverage unit.
`default_nettype none

package ppc_pkg;

    localparam int PIX_W       = 12;
    localparam int ADDR_W      = 24;
    localparam int COLOR_W     = 32;
    localparam int COORD_RAW_W = 15;
    localparam int DIM_W       = 13;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int DEF_MAX_FRAME_DIM = 4096;
    localparam int DEF_COORD_BITS    = 15;

    localparam logic [DIM_W-1:0] RESET_FRAME_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_FRAME_HEIGHT = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHAPE_MODE   = 3'd0,
        REG_FIRST_X      = 3'd1,
        REG_FIRST_Y      = 3'd2,
        REG_SECOND_X     = 3'd3,
        REG_SECOND_Y     = 3'd4,
        REG_DRAW_COLOR   = 3'd5,
        REG_FRAME_WIDTH  = 3'd6,
        REG_FRAME_HEIGHT = 3'd7
    } reg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        SHAPE_RECT   = 2'd0,
        SHAPE_CIRCLE = 2'd1,
        SHAPE_LINE   = 2'd2
    } shape_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } pixel_in_t;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  write_address;
        logic [COLOR_W-1:0] write_color;
    } pixel_out_t;

    typedef struct packed {
        logic [MODE_W-1:0]      shape_mode;
        logic [COORD_RAW_W-1:0] first_x;
        logic [COORD_RAW_W-1:0] first_y;
        logic [COORD_RAW_W-1:0] second_x;
        logic [COORD_RAW_W-1:0] second_y;
        logic [COLOR_W-1:0]     draw_color;
        logic [DIM_W-1:0]       frame_width;
        logic [DIM_W-1:0]       frame_height;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppc_icpt_div.sv =====
// Sequential restoring divider that works out the line intercept term after each setup change.
`default_nettype none

module ppc_icpt_div
    import ppc_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         restart,
    input  wire logic signed [COORD_BITS-1:0] ax,
    input  wire logic signed [COORD_BITS-1:0] ay,
    input  wire logic signed [COORD_BITS-1:0] bx,
    input  wire logic signed [COORD_BITS-1:0] by,
    output logic                              busy,
    output logic signed [2*COORD_BITS:0]      q0
);

    localparam int CB    = COORD_BITS;
    localparam int NW    = 2 * CB;
    localparam int CNT_W = $clog2(NW);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } div_state_t;

    div_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NW-1:0]      acc_reg, acc_next;
    logic [CB:0]        rem_reg, rem_next;
    logic [CB:0]        den_reg, den_next;
    logic               neg_reg, neg_next;

    logic signed [CB:0]   dxl, dyl, dyn;
    logic                 dneg;
    logic signed [NW:0]   prod;
    logic [CB+1:0]        trial;
    logic                 fits;

    assign dxl  = (CB+1)'(bx) - (CB+1)'(ax);
    assign dyl  = (CB+1)'(by) - (CB+1)'(ay);
    assign dneg = dxl[CB];
    assign dyn  = dneg ? -dyl : dyl;
    assign prod = dyn * ax;

    assign trial = {rem_reg, acc_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            ST_LOAD: begin
                neg_next   = prod[NW];
                acc_next   = prod[NW] ? NW'(-prod) : NW'(prod);
                den_next   = dneg ? (CB+1)'(-dxl) : (CB+1)'(dxl);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = fits ? (CB+1)'(trial - {1'b0, den_reg}) : trial[CB:0];
                acc_next = {acc_reg[NW-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                state_next = ST_DONE;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
        if (restart) begin
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy = (state_reg != ST_DONE);
    assign q0   = neg_reg ? -signed'({1'b0, acc_reg}) : signed'({1'b0, acc_reg});

endmodule

`default_nettype wire

// ===== hw/rtl/ppc_pipe.sv =====
// Three-stage coverage datapath: differences and spans, products, then compares and result.
`default_nettype none

module ppc_pipe
    import ppc_pkg::*;
#(
    parameter int COORD_BITS    = DEF_COORD_BITS,
    parameter int MAX_FRAME_DIM = DEF_MAX_FRAME_DIM
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire pixel_in_t                    in_item,
    input  wire logic [MODE_W-1:0]            mode,
    input  wire logic signed [COORD_BITS-1:0] ax,
    input  wire logic signed [COORD_BITS-1:0] ay,
    input  wire logic signed [COORD_BITS-1:0] bx,
    input  wire logic signed [COORD_BITS-1:0] by,
    input  wire logic [COLOR_W-1:0]           color,
    input  wire logic [DIM_W-1:0]             frame_width,
    input  wire logic [DIM_W-1:0]             frame_height,
    input  wire logic signed [2*COORD_BITS:0] q0,
    output logic                              out_valid,
    output pixel_out_t                        out_item
);

    localparam int CB   = COORD_BITS;
    localparam int SW   = CB + 2;
    localparam int TW   = 2 * CB + 2;
    localparam int XW   = PIX_W + 2;
    localparam int NLW  = SW + XW;
    localparam int PW   = TW + SW;
    localparam int MW   = PW + 1;
    localparam int FD_W = $clog2(MAX_FRAME_DIM + 1);
    localparam int EW   = (FD_W > DIM_W) ? FD_W : DIM_W;
    localparam int AW   = PIX_W + EW;

    // Stage 1 logic
    logic signed [SW-1:0] sx, sy, axe, aye, bxe, bye, dxl, dyl, dyn, dd;
    logic signed [TW-1:0] t;
    logic [EW-1:0]        fw_e, fh_e, fw_sat, fh_sat;
    logic                 in_frame, rect_hit, xspan, yspan, vert_hit;

    assign sx  = SW'(signed'({1'b0, in_item.pixel_x}));
    assign sy  = SW'(signed'({1'b0, in_item.pixel_y}));
    assign axe = SW'(ax);
    assign aye = SW'(ay);
    assign bxe = SW'(bx);
    assign bye = SW'(by);
    assign dxl = bxe - axe;
    assign dyl = bye - aye;
    assign dyn = dxl[SW-1] ? -dyl : dyl;
    assign dd  = dxl[SW-1] ? -dxl : dxl;
    assign t   = TW'(sy) - TW'(aye) + TW'(q0);

    assign fw_e   = EW'(frame_width);
    assign fh_e   = EW'(frame_height);
    assign fw_sat = (fw_e > EW'(MAX_FRAME_DIM)) ? EW'(MAX_FRAME_DIM) : fw_e;
    assign fh_sat = (fh_e > EW'(MAX_FRAME_DIM)) ? EW'(MAX_FRAME_DIM) : fh_e;
    assign in_frame = (EW'(in_item.pixel_x) < fw_sat) && (EW'(in_item.pixel_y) < fh_sat);

    assign rect_hit = (bxe > 0) && (bye > 0) && (axe <= sx) && (sx < axe + bxe)
                      && (aye <= sy) && (sy < aye + bye);
    assign xspan    = ((sx >= axe) && (sx <= bxe)) || ((sx >= bxe) && (sx <= axe));
    assign yspan    = ((sy >= aye) && (sy <= bye)) || ((sy >= bye) && (sy <= aye));
    assign vert_hit = (sx == axe) && yspan;

    logic                 v1_reg;
    logic [MODE_W-1:0]    mode1_reg;
    logic                 frame1_reg, rect1_reg, vert1_reg, vhit1_reg, xspan1_reg;
    logic signed [SW-1:0] dxc1_reg, dyc1_reg, dyn1_reg, d1_reg;
    logic signed [CB-1:0] r1_reg;
    logic signed [TW-1:0] t1_reg;
    logic [PIX_W-1:0]     px1_reg, py1_reg;
    logic [EW-1:0]        fw1_reg;
    logic [COLOR_W-1:0]   color1_reg;

    // Stage 2 logic
    logic signed [XW-1:0] x0s, x1s;
    assign x0s = XW'(signed'({1'b0, px1_reg}));
    assign x1s = x0s + XW'(1);

    logic                  v2_reg;
    logic [MODE_W-1:0]     mode2_reg;
    logic                  frame2_reg, rect2_reg, vert2_reg, vhit2_reg, xspan2_reg, rneg2_reg;
    logic                  dneg2_reg;
    logic [2*SW-1:0]       sqx2_reg, sqy2_reg;
    logic [2*CB-1:0]       r2_reg;
    logic signed [PW-1:0]  p2_reg;
    logic signed [SW-1:0]  d2_reg;
    logic signed [NLW-1:0] n1_reg, n2_reg;
    logic [AW-1:0]         rowa2_reg;
    logic [PIX_W-1:0]      px2_reg;
    logic [COLOR_W-1:0]    color2_reg;

    logic signed [2*SW-1:0] sqx_s, sqy_s;
    logic signed [2*CB-1:0] r2_s;
    assign sqx_s = dxc1_reg * dxc1_reg;
    assign sqy_s = dyc1_reg * dyc1_reg;
    assign r2_s  = r1_reg * r1_reg;

    // Stage 3 logic: the quotient bounds are tested by cross multiplication against t*d.
    logic signed [MW-1:0] pe, pp, pm, lown, highn;
    logic                 low_ok, high_ok, line_hit, circ_hit, hit;
    logic [2*SW:0]        dist2;

    assign pe     = MW'(p2_reg);
    assign pp     = pe + MW'(d2_reg);
    assign pm     = pe - MW'(d2_reg);
    assign lown   = dneg2_reg ? MW'(n2_reg) : MW'(n1_reg);
    assign highn  = dneg2_reg ? MW'(n1_reg) : MW'(n2_reg);
    assign low_ok  = lown[MW-1] ? (lown <= pe) : (lown < pp);
    assign high_ok = highn[MW-1] ? (highn > pm) : (highn >= pe);
    assign line_hit = vert2_reg ? vhit2_reg : (xspan2_reg && low_ok && high_ok);
    assign dist2    = (2*SW+1)'(sqx2_reg) + (2*SW+1)'(sqy2_reg);
    assign circ_hit = !rneg2_reg && (dist2 <= (2*SW+1)'(r2_reg));

    always_comb begin
        case (mode2_reg)
            SHAPE_RECT:   hit = frame2_reg && rect2_reg;
            SHAPE_CIRCLE: hit = frame2_reg && circ_hit;
            SHAPE_LINE:   hit = frame2_reg && line_hit;
            default:      hit = 1'b0;
        endcase
    end

    logic       v3_reg;
    pixel_out_t out3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg  <= mode;
            frame1_reg <= in_frame;
            rect1_reg  <= rect_hit;
            vert1_reg  <= (dxl == 0);
            vhit1_reg  <= vert_hit;
            xspan1_reg <= xspan;
            dxc1_reg   <= sx - axe;
            dyc1_reg   <= sy - aye;
            dyn1_reg   <= dyn;
            d1_reg     <= dd;
            r1_reg     <= bx;
            t1_reg     <= t;
            px1_reg    <= in_item.pixel_x;
            py1_reg    <= in_item.pixel_y;
            fw1_reg    <= fw_sat;
            color1_reg <= color;

            mode2_reg  <= mode1_reg;
            frame2_reg <= frame1_reg;
            rect2_reg  <= rect1_reg;
            vert2_reg  <= vert1_reg;
            vhit2_reg  <= vhit1_reg;
            xspan2_reg <= xspan1_reg;
            rneg2_reg  <= r1_reg[CB-1];
            dneg2_reg  <= dyn1_reg[SW-1];
            sqx2_reg   <= unsigned'(sqx_s);
            sqy2_reg   <= unsigned'(sqy_s);
            r2_reg     <= unsigned'(r2_s);
            p2_reg     <= t1_reg * d1_reg;
            d2_reg     <= d1_reg;
            n1_reg     <= dyn1_reg * x0s;
            n2_reg     <= dyn1_reg * x1s;
            rowa2_reg  <= py1_reg * fw1_reg;
            px2_reg    <= px1_reg;
            color2_reg <= color1_reg;

            out3_reg.write_enable  <= hit;
            out3_reg.write_address <= hit ? ADDR_W'(rowa2_reg + AW'(px2_reg)) : '0;
            out3_reg.write_color   <= hit ? color2_reg : '0;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = out3_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/primitive_pixel_coverage_unit.sv =====
// Top level of the primitive pixel coverage unit: setup registers, intercept divider, datapath.
//
// The unit tests one framebuffer pixel per item against a single configured primitive:
// a rectangle, a filled circle or a naive line. Items arrive on the s_ channel as a
// column and row; each gives exactly one result item on the m_ channel with a write
// enable, the linear address row * width + column, and the drawing colour (address and
// colour are zero when the pixel is not painted). Pixels outside the frame are never painted.
// Setup registers are written through cfg_we, cfg_index and cfg_data; the user must do so
// while no item is in flight; the block does not enforce it. A write takes effect at once.
// The result of an accepted item passes the three register stages of the datapath and is shown
// on the m_ channel from the last of them. One item can be taken every cycle while the divider
// is idle and the receiver does not stall; the three register stages of the datapath advance
// together.
// The line intercept term is produced by a bit-serial divider that runs after reset and after
// every register write; s_ready stays low while it runs.
// Reset clears all valid bits and loads the register defaults (frame 640 by 480).
// When the receiver holds m_ready low with a result waiting, the whole pipeline stalls
// and s_ready drops; nothing is lost or repeated.
`default_nettype none

module primitive_pixel_coverage_unit
    import ppc_pkg::*;
#(
    parameter int COORD_BITS    = DEF_COORD_BITS,
    parameter int MAX_FRAME_DIM = DEF_MAX_FRAME_DIM
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pixel_in_t             s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output pixel_out_t                 m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int XW = CB + COORD_RAW_W;

    cfg_t cfg_reg;

    // Register file; each write also restarts the intercept divider.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg              <= '0;
            cfg_reg.frame_width  <= RESET_FRAME_WIDTH;
            cfg_reg.frame_height <= RESET_FRAME_HEIGHT;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_SHAPE_MODE:   cfg_reg.shape_mode   <= cfg_data[MODE_W-1:0];
                REG_FIRST_X:      cfg_reg.first_x      <= cfg_data[COORD_RAW_W-1:0];
                REG_FIRST_Y:      cfg_reg.first_y      <= cfg_data[COORD_RAW_W-1:0];
                REG_SECOND_X:     cfg_reg.second_x     <= cfg_data[COORD_RAW_W-1:0];
                REG_SECOND_Y:     cfg_reg.second_y     <= cfg_data[COORD_RAW_W-1:0];
                REG_DRAW_COLOR:   cfg_reg.draw_color   <= cfg_data[COLOR_W-1:0];
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Coordinates are the low COORD_BITS bits of each raw field, read as two's complement.
    logic [XW-1:0]        fx_e, fy_e, sx_e, sy_e;
    logic signed [CB-1:0] ax, ay, bx, by;

    assign fx_e = XW'(cfg_reg.first_x);
    assign fy_e = XW'(cfg_reg.first_y);
    assign sx_e = XW'(cfg_reg.second_x);
    assign sy_e = XW'(cfg_reg.second_y);
    assign ax   = signed'(fx_e[CB-1:0]);
    assign ay   = signed'(fy_e[CB-1:0]);
    assign bx   = signed'(sx_e[CB-1:0]);
    assign by   = signed'(sy_e[CB-1:0]);

    logic                signed [2*CB:0] q0;
    logic                div_busy;
    logic                pipe_en;

    ppc_icpt_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_we),
        .ax      (ax),
        .ay      (ay),
        .bx      (bx),
        .by      (by),
        .busy    (div_busy),
        .q0      (q0)
    );

    // The pipeline advances whenever the output register is empty or being taken.
    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en && !div_busy;

    ppc_pipe #(
        .COORD_BITS    (COORD_BITS),
        .MAX_FRAME_DIM (MAX_FRAME_DIM)
    ) u_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (pipe_en),
        .in_valid     (s_valid && s_ready),
        .in_item      (s_data),
        .mode         (cfg_reg.shape_mode),
        .ax           (ax),
        .ay           (ay),
        .bx           (bx),
        .by           (by),
        .color        (cfg_reg.draw_color),
        .frame_width  (cfg_reg.frame_width),
        .frame_height (cfg_reg.frame_height),
        .q0           (q0),
        .out_valid    (m_valid),
        .out_item     (m_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ppc_checker.sv =====
// Port-level checker for the primitive pixel coverage unit and its bind statement.
`default_nettype none

module ppc_checker
    import ppc_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire pixel_out_t m_data,
    input wire logic       cfg_we
);

    // A result must hold while the receiver stalls.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Unpainted pixels carry zero address and colour.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.write_enable |->
            m_data.write_address == '0 && m_data.write_color == '0)
        else $error("unpainted result has non-zero payload");

    // A register write restarts the intercept divider, which blocks input.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("input taken while the divider restarts");

    // Leaving reset, no result is shown.
    a_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind primitive_pixel_coverage_unit ppc_checker u_ppc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .cfg_we  (cfg_we)
);

`default_nettype wire
